[design/jbl_pkg.sv]
`timescale 1ns / 1ps
package jbl_pkg;

  // Result queue geometry
  localparam int unsigned RqDepth = 8;
  localparam int unsigned RqAw    = $clog2(RqDepth);
  localparam int unsigned RqCw    = $clog2(RqDepth + 1);
  // Most results one request can produce
  localparam int unsigned MaxRes  = 3;

  // Token type codes
  typedef enum logic [3:0] {
    TOK_OBJB    = 4'd0,
    TOK_OBJE    = 4'd1,
    TOK_ARRB    = 4'd2,
    TOK_ARRE    = 4'd3,
    TOK_COLON   = 4'd4,
    TOK_COMMA   = 4'd5,
    TOK_STRING  = 4'd6,
    TOK_TRUE    = 4'd7,
    TOK_FALSE   = 4'd8,
    TOK_INT     = 4'd9,
    TOK_DEC     = 4'd10,
    TOK_NULL    = 4'd11,
    TOK_INVALID = 4'd12,
    TOK_END     = 4'd13
  } tok_e;

  // Lexer mode, one-hot
  typedef enum logic [14:0] {
    M_IDLE  = 15'h0001,
    M_SLASH = 15'h0002,
    M_LINE  = 15'h0004,
    M_BLOCK = 15'h0008,
    M_STR   = 15'h0010,
    M_ESC   = 15'h0020,
    M_HEX   = 15'h0040,
    M_NSIGN = 15'h0080,
    M_INT   = 15'h0100,
    M_FRAC1 = 15'h0200,
    M_FRAC  = 15'h0400,
    M_EXP1  = 15'h0800,
    M_EXPS  = 15'h1000,
    M_EXP   = 15'h2000,
    M_KEY   = 15'h4000
  } mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] token_type;
    logic [7:0] text_byte;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] hex_accum;
    logic [1:0]  hex_count;
    logic        seen_decimal;
    logic        star_seen;
    logic [2:0]  keyword_pos;
    logic [2:0]  keyword_alive;
  } lex_state_t;

  // Write side of the result queue
  typedef struct packed {
    logic [1:0]              count;
    out_t [MaxRes-1:0]       res;
  } push_t;

endpackage

[design/json_byte_lexer.sv]
`timescale 1ns / 1ps
// Results: each accepted request's results are registered into the result queue
//   and leave from its head one per cycle, in order, while out_stall_i is low.
// Throughput: one request per cycle while the 8-entry result queue has room
//   for three more results; sustained output is one result per cycle when not stalled.
// Reset: rst_ni (async, active low) puts the lexer between tokens and empties
//   the result queue.
module json_byte_lexer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  jbl_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output jbl_pkg::out_t out_res_o
);
  import jbl_pkg::*;

  lex_state_t state_q, state_d;
  push_t      step_push;
  push_t      push;
  logic       room;
  logic       accept;

  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  jbl_step u_step (
    .state_i (state_q),
    .req_i   (in_req_i),
    .state_o (state_d),
    .push_o  (step_push)
  );

  // Only an accepted request writes results
  always_comb begin
    push       = step_push;
    push.count = accept ? step_push.count : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode          <= M_IDLE;
      state_q.hex_accum     <= '0;
      state_q.hex_count     <= '0;
      state_q.seen_decimal  <= 1'b0;
      state_q.star_seen     <= 1'b0;
      state_q.keyword_pos   <= '0;
      state_q.keyword_alive <= 3'b111;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  jbl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

[design/jbl_step.sv]
`timescale 1ns / 1ps
module jbl_step (
  input  jbl_pkg::lex_state_t state_i,
  input  jbl_pkg::in_t        req_i,
  output jbl_pkg::lex_state_t state_o,
  output jbl_pkg::push_t      push_o
);
  import jbl_pkg::*;

  typedef struct packed {
    lex_state_t st;
    logic       emit;
    out_t       res;
  } idle_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic out_t text_res(logic [7:0] c);
    out_t r;
    r.kind        = 1'b0;
    r.token_type  = 4'd0;
    r.text_byte   = c;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic out_t type_res(tok_e t);
    out_t r;
    r.kind        = 1'b1;
    r.token_type  = t;
    r.text_byte   = 8'd0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Keyword spelling: 0 true, 1 false, 2 null; zero past the end
  function automatic logic [7:0] kw_char(int unsigned i, logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    case (i)
      0: case (pos)
           3'd0: ch = 8'h74; 3'd1: ch = 8'h72; 3'd2: ch = 8'h75; 3'd3: ch = 8'h65;
           default: ch = 8'd0;
         endcase
      1: case (pos)
           3'd0: ch = 8'h66; 3'd1: ch = 8'h61; 3'd2: ch = 8'h6C; 3'd3: ch = 8'h73;
           3'd4: ch = 8'h65;
           default: ch = 8'd0;
         endcase
      default: case (pos)
           3'd0: ch = 8'h6E; 3'd1: ch = 8'h75; 3'd2: ch = 8'h6C; 3'd3: ch = 8'h6C;
           default: ch = 8'd0;
         endcase
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(int unsigned i);
    return (i == 1) ? 3'd5 : 3'd4;
  endfunction

  function automatic tok_e kw_tok(int unsigned i);
    tok_e t;
    case (i)
      0:       t = TOK_TRUE;
      1:       t = TOK_FALSE;
      default: t = TOK_NULL;
    endcase
    return t;
  endfunction

  // Drop candidates that do not match this letter
  function automatic lex_state_t key_letter(lex_state_t s, logic [7:0] c);
    lex_state_t r;
    r = s;
    for (int unsigned i = 0; i < 3; i++) begin
      if (s.keyword_alive[i] &&
          ((s.keyword_pos >= kw_len(i)) || (kw_char(i, s.keyword_pos) != c))) begin
        r.keyword_alive[i] = 1'b0;
      end
    end
    if (s.keyword_pos != 3'd7) begin
      r.keyword_pos = s.keyword_pos + 3'd1;
    end
    return r;
  endfunction

  function automatic tok_e key_type(lex_state_t s);
    tok_e t;
    t = TOK_INVALID;
    for (int unsigned i = 0; i < 3; i++) begin
      if (s.keyword_alive[i] && (s.keyword_pos == kw_len(i))) t = kw_tok(i);
    end
    return t;
  endfunction

  // A byte seen between tokens: at most one result
  function automatic idle_t idle_byte(lex_state_t s, logic [7:0] c);
    idle_t r;
    r.st      = s;
    r.st.mode = M_IDLE;
    r.emit    = 1'b0;
    r.res     = text_res(c);
    case (c) inside
      8'h20, 8'h09, 8'h0A, 8'h0D: ;
      8'h2F: r.st.mode = M_SLASH;
      8'h7B: begin r.emit = 1'b1; r.res = type_res(TOK_OBJB); end
      8'h7D: begin r.emit = 1'b1; r.res = type_res(TOK_OBJE); end
      8'h5B: begin r.emit = 1'b1; r.res = type_res(TOK_ARRB); end
      8'h5D: begin r.emit = 1'b1; r.res = type_res(TOK_ARRE); end
      8'h3A: begin r.emit = 1'b1; r.res = type_res(TOK_COLON); end
      8'h2C: begin r.emit = 1'b1; r.res = type_res(TOK_COMMA); end
      8'h22: r.st.mode = M_STR;
      8'h2D, 8'h2B: begin
        r.emit            = 1'b1;
        r.st.seen_decimal = 1'b0;
        r.st.mode         = M_NSIGN;
      end
      default: begin
        if (is_digit(c)) begin
          r.emit            = 1'b1;
          r.st.seen_decimal = 1'b0;
          r.st.mode         = M_INT;
        end else if (is_lower(c)) begin
          r.st.keyword_pos   = 3'd0;
          r.st.keyword_alive = 3'b111;
          r.st               = key_letter(r.st, c);
          r.st.mode          = M_KEY;
          r.emit             = 1'b1;
        end else begin
          r.emit = 1'b1;
          r.res  = type_res(TOK_INVALID);
        end
      end
    endcase
    return r;
  endfunction

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (is_digit(c)) begin
      d = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      d = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      d = c - 8'h37;
    end
    return {is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
            ((c >= 8'h41) && (c <= 8'h46)), d[3:0]};
  endfunction

  // One lexer step
  always_comb begin
    lex_state_t         s;
    out_t [MaxRes-1:0]  res;
    logic [1:0]         n;
    idle_t              id;
    logic [7:0]         c;
    logic [4:0]         hd;
    logic [15:0]        acc;

    s   = state_i;
    res = '0;
    n   = 2'd0;
    c   = req_i.data_byte;
    id  = idle_byte(state_i, c);
    hd  = hex_digit(c);
    acc = {state_i.hex_accum[11:0], hd[3:0]};

    if (req_i.end_of_input) begin
      // Flush the pending token, then mark the end
      unique case (state_i.mode)
        M_IDLE, M_LINE: ;
        M_INT: begin
          res[n] = type_res(state_i.seen_decimal ? TOK_DEC : TOK_INT); n = n + 2'd1;
        end
        M_FRAC, M_EXP: begin
          res[n] = type_res(TOK_DEC); n = n + 2'd1;
        end
        M_KEY: begin
          res[n] = type_res(key_type(state_i)); n = n + 2'd1;
        end
        default: begin
          res[n] = type_res(TOK_INVALID); n = n + 2'd1;
        end
      endcase
      res[n] = type_res(TOK_END); n = n + 2'd1;
      s.mode      = M_IDLE;
      s.star_seen = 1'b0;
      s.hex_count = 2'd0;
    end else begin
      unique case (state_i.mode)
        M_SLASH: begin
          if (c == 8'h2F) begin
            s.mode = M_LINE;
          end else if (c == 8'h2A) begin
            s.mode      = M_BLOCK;
            s.star_seen = 1'b0;
          end else begin
            res[n] = type_res(TOK_INVALID); n = n + 2'd1;
            s.mode = M_IDLE;
          end
        end
        M_LINE: begin
          if (c == 8'h0A) s.mode = M_IDLE;
        end
        M_BLOCK: begin
          if (c == 8'h2A) begin
            s.star_seen = 1'b1;
          end else if ((c == 8'h2F) && state_i.star_seen) begin
            s.star_seen = 1'b0;
            s.mode      = M_IDLE;
          end else begin
            s.star_seen = 1'b0;
          end
        end
        M_STR: begin
          if (c == 8'h22) begin
            res[n] = type_res(TOK_STRING); n = n + 2'd1;
            s.mode = M_IDLE;
          end else if (c == 8'h5C) begin
            s.mode = M_ESC;
          end else begin
            res[n] = text_res(c); n = n + 2'd1;
          end
        end
        M_ESC: begin
          s.mode = M_STR;
          case (c) inside
            8'h22, 8'h5C, 8'h2F: begin res[n] = text_res(c); n = n + 2'd1; end
            8'h62: begin res[n] = text_res(8'h08); n = n + 2'd1; end
            8'h66: begin res[n] = text_res(8'h0C); n = n + 2'd1; end
            8'h6E: begin res[n] = text_res(8'h0A); n = n + 2'd1; end
            8'h72: begin res[n] = text_res(8'h0D); n = n + 2'd1; end
            8'h74: begin res[n] = text_res(8'h09); n = n + 2'd1; end
            8'h75: begin
              s.hex_accum = 16'd0;
              s.hex_count = 2'd0;
              s.mode      = M_HEX;
            end
            default: begin
              res[n] = type_res(TOK_INVALID); n = n + 2'd1;
              s.mode = M_IDLE;
            end
          endcase
        end
        M_HEX: begin
          if (!hd[4]) begin
            res[n] = type_res(TOK_INVALID); n = n + 2'd1;
            s.mode = M_IDLE;
          end else begin
            s.hex_accum = acc;
            s.hex_count = state_i.hex_count + 2'd1;
            if (state_i.hex_count == 2'd3) begin
              // Fourth digit: encode the code point as UTF-8
              if (acc <= 16'h007F) begin
                res[n] = text_res(acc[7:0]); n = n + 2'd1;
              end else if (acc <= 16'h07FF) begin
                res[n] = text_res(8'hC0 | {3'd0, acc[10:6]}); n = n + 2'd1;
                res[n] = text_res(8'h80 | {2'd0, acc[5:0]});  n = n + 2'd1;
              end else begin
                res[n] = text_res(8'hE0 | {4'd0, acc[15:12]}); n = n + 2'd1;
                res[n] = text_res(8'h80 | {2'd0, acc[11:6]});  n = n + 2'd1;
                res[n] = text_res(8'h80 | {2'd0, acc[5:0]});   n = n + 2'd1;
              end
              s.hex_count = 2'd0;
              s.mode      = M_STR;
            end
          end
        end
        M_NSIGN, M_FRAC1, M_EXPS: begin
          if (is_digit(c)) begin
            res[n] = text_res(c); n = n + 2'd1;
            s.mode = (state_i.mode == M_NSIGN) ? M_INT :
                     (state_i.mode == M_FRAC1) ? M_FRAC : M_EXP;
          end else begin
            res[n] = type_res(TOK_INVALID); n = n + 2'd1;
            s.mode = M_IDLE;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            res[n] = text_res(c); n = n + 2'd1;
          end else if (c == 8'h2E) begin
            res[n] = text_res(c); n = n + 2'd1;
            s.seen_decimal = 1'b1;
            s.mode         = M_FRAC1;
          end else if ((c == 8'h65) || (c == 8'h45)) begin
            res[n] = text_res(c); n = n + 2'd1;
            s.seen_decimal = 1'b1;
            s.mode         = M_EXP1;
          end else begin
            res[n] = type_res(state_i.seen_decimal ? TOK_DEC : TOK_INT); n = n + 2'd1;
            s = id.st;
            if (id.emit) begin res[n] = id.res; n = n + 2'd1; end
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            res[n] = text_res(c); n = n + 2'd1;
          end else if ((c == 8'h65) || (c == 8'h45)) begin
            res[n] = text_res(c); n = n + 2'd1;
            s.mode = M_EXP1;
          end else begin
            res[n] = type_res(TOK_DEC); n = n + 2'd1;
            s = id.st;
            if (id.emit) begin res[n] = id.res; n = n + 2'd1; end
          end
        end
        M_EXP1: begin
          if (is_digit(c)) begin
            res[n] = text_res(c); n = n + 2'd1;
            s.mode = M_EXP;
          end else if ((c == 8'h2B) || (c == 8'h2D)) begin
            res[n] = text_res(c); n = n + 2'd1;
            s.mode = M_EXPS;
          end else begin
            res[n] = type_res(TOK_INVALID); n = n + 2'd1;
            s.mode = M_IDLE;
          end
        end
        M_EXP: begin
          if (is_digit(c)) begin
            res[n] = text_res(c); n = n + 2'd1;
          end else begin
            res[n] = type_res(TOK_DEC); n = n + 2'd1;
            s = id.st;
            if (id.emit) begin res[n] = id.res; n = n + 2'd1; end
          end
        end
        M_KEY: begin
          if (is_lower(c)) begin
            s = key_letter(state_i, c);
            res[n] = text_res(c); n = n + 2'd1;
          end else begin
            res[n] = type_res(key_type(state_i)); n = n + 2'd1;
            s = id.st;
            if (id.emit) begin res[n] = id.res; n = n + 2'd1; end
          end
        end
        default: begin
          s = id.st;
          if (id.emit) begin res[n] = id.res; n = n + 2'd1; end
        end
      endcase
    end

    // Flag the final result of this request
    if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;

    state_o      = s;
    push_o.count = n;
    push_o.res   = res;
  end

endmodule

[design/jbl_fifo.sv]
`timescale 1ns / 1ps
module jbl_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jbl_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output jbl_pkg::out_t  out_res_o
);
  import jbl_pkg::*;

  out_t              mem [RqDepth];
  logic [RqAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [RqAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [RqCw-1:0]   count_q, count_d;
  logic              pop;

  // Room for a worst-case request
  assign room_o      = count_q <= RqCw'(RqDepth - MaxRes);
  assign out_valid_o = count_q != '0;
  assign out_res_o   = mem[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + RqAw'(push_i.count);
    rd_ptr_d = rd_ptr_q + RqAw'(pop);
    count_d  = count_q + RqCw'(push_i.count) - RqCw'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Up to three entries written per cycle, into free slots only
  always_ff @(posedge clk_i) begin
    for (int unsigned k = 0; k < MaxRes; k++) begin
      if (k < 32'(push_i.count)) begin
        mem[wr_ptr_q + RqAw'(k)] <= push_i.res[k];
      end
    end
  end

endmodule
